@@ rtl/bua_pkg.sv @@
// Shared types, codes and the control store of the bitmap unit allocator.
// Used by bitmap_unit_allocator_top; depends on nothing.
`default_nettype none

package bua_pkg;

  localparam int DEF_WORDS      = 64;
  localparam int DEF_REQUESTERS = 16;

  localparam int WIU_W  = 7;
  localparam int UNIT_W = 12;
  localparam int FREE_W = 13;
  localparam int REQ_W  = 4;
  localparam int REQ_CODES = 1 << REQ_W;

  localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_CLEAR,
    STEP_ALC_TEST,
    STEP_ALC_WORD,
    STEP_ALC_SHARE,
    STEP_FRE_TEST,
    STEP_FRE_WORD,
    STEP_DONE
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TAKE,
    OP_READ_CUR,
    OP_SET_BIT,
    OP_SHARE,
    OP_READ_UNIT,
    OP_CLEAR_BIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ITEM,
    C_CUR_OUT,
    C_WORD_FULL,
    C_STEPS_DONE,
    C_UNIT_OUT,
    C_OUT_BUSY,
    C_CLEAR_DONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t next;
    logic  dispatch;
    logic  take;
  } ctrl_t;

  function automatic ctrl_t bua_rom(step_t s);
    ctrl_t c;
    c.op       = OP_NONE;
    c.cond     = C_NONE;
    c.jump     = STEP_IDLE;
    c.next     = STEP_IDLE;
    c.dispatch = 1'b0;
    c.take     = 1'b0;
    case (s)
      STEP_IDLE: begin
        c.op = OP_TAKE;     c.cond = C_NO_ITEM;    c.jump = STEP_IDLE;
        c.next = STEP_ALC_TEST; c.dispatch = 1'b1; c.take = 1'b1;
      end
      STEP_CLEAR: begin
        c.op = OP_CLEAR;    c.cond = C_CLEAR_DONE; c.jump = STEP_IDLE;
        c.next = STEP_CLEAR;
      end
      STEP_ALC_TEST: begin
        c.op = OP_READ_CUR; c.cond = C_CUR_OUT;    c.jump = STEP_ALC_SHARE;
        c.next = STEP_ALC_WORD;
      end
      STEP_ALC_WORD: begin
        c.op = OP_SET_BIT;  c.cond = C_WORD_FULL;  c.jump = STEP_ALC_SHARE;
        c.next = STEP_DONE;
      end
      STEP_ALC_SHARE: begin
        c.op = OP_SHARE;    c.cond = C_STEPS_DONE; c.jump = STEP_DONE;
        c.next = STEP_ALC_TEST;
      end
      STEP_FRE_TEST: begin
        c.op = OP_READ_UNIT; c.cond = C_UNIT_OUT;  c.jump = STEP_DONE;
        c.next = STEP_FRE_WORD;
      end
      STEP_FRE_WORD: begin
        c.op = OP_CLEAR_BIT; c.next = STEP_DONE;
      end
      STEP_DONE: begin
        c.op = OP_EMIT;     c.cond = C_OUT_BUSY;   c.jump = STEP_DONE;
        c.next = STEP_IDLE;
      end
      default: begin
        c.next = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bua_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the unit bitmap; depends on nothing.
`default_nettype none

module bua_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_unit_allocator_top.sv @@
// Bitmap unit allocator: microcoded sequencer over a bitmap RAM.
// Depends on bua_pkg and bua_ram.
//
// Requests enter on s_axis (tuser: action, tdata: requester, unit_index); one
// result per request leaves on m_axis (tuser: status, tdata: allocated_unit,
// free_units). cfg_valid/cfg_data write words_in_use; cfg_ready is always high.
// Each request is a short program from the control store: an allocate reads
// the requester's hint word, and if that word is out of range or full steps
// the shared hint and reads again; it then sets the lowest clear bit with one
// read-modify-write of the bitmap RAM. A free is one read-modify-write.
// A request is taken only at the idle step, so the next one waits until the
// last has passed its final step. Each full word skipped on an allocate, and each
// out-of-range word, adds steps, since the single RAM read port has a registered
// read. A failing allocate tries
// the hint word and then up to n+1 words from the shared hint.
// After reset the bitmap is cleared word by word, during which
// s_axis_tready stays low; configuration writes are taken throughout.
// A stalled result holds m_axis until transferred; the next request may be
// taken meanwhile and waits at its final step for the output register.
`default_nettype none

module bitmap_unit_allocator_top
  import bua_pkg::*;
#(
  parameter int WORDS      = DEF_WORDS,
  parameter int REQUESTERS = DEF_REQUESTERS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // requester[3:0], unit_index[15:4]
  input  wire logic               s_axis_tuser,   // action
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [31:0]        m_axis_tdata,   // allocated_unit[11:0], free_units[24:12]
  output logic      [1:0]         m_axis_tuser,   // status
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [WIU_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(WORDS);
  localparam int HINTS  = (REQUESTERS < REQ_CODES) ? REQUESTERS : REQ_CODES;
  localparam int HIDX_W = (HINTS > 1) ? $clog2(HINTS) : 1;
  localparam int HINT_W = ($clog2(REQUESTERS + 2) > WIU_W) ? $clog2(REQUESTERS + 2) : WIU_W;
  localparam int STEP_W = WIU_W + 1;

  step_t step, step_next;
  ctrl_t ctrl;

  logic [WIU_W-1:0]  words_in_use;
  logic [WIU_W-1:0]  n_words;
  logic [HINT_W-1:0] hint [HINTS];
  logic [HINT_W-1:0] shared_hint;
  logic [FREE_W-1:0] allocated_count;
  logic [ADDR_W-1:0] clr_addr;

  logic              action;
  logic [HIDX_W-1:0] req;
  logic [UNIT_W-1:0] unit;
  logic [HINT_W-1:0] cur;
  logic [HINT_W-1:0] shr;
  logic [STEP_W-1:0] steps;
  status_t           status;
  logic [UNIT_W-1:0] granted;
  logic [ADDR_W-1:0] rd_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [63:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [63:0]       rdata;

  logic [HIDX_W-1:0] req_map [REQ_CODES];
  logic [HIDX_W-1:0] in_req;
  logic [HINT_W-1:0] n_hint;
  logic [HINT_W-1:0] share_t;
  logic [63:0]       low_clear;
  logic [5:0]        bit_idx;
  logic [63:0]       free_mask;
  logic              word_full;
  logic              cur_out;
  logic              steps_done;
  logic              unit_out;
  logic              bit_set;
  logic              out_busy;
  logic              cond_hit;
  logic [FREE_W-1:0] total_units;
  logic [FREE_W-1:0] free_units;

  for (genvar g = 0; g < REQ_CODES; g++) begin : g_req_map
    assign req_map[g] = HIDX_W'(g % REQUESTERS);
  end

  assign cfg_ready     = 1'b1;
  assign n_words       = (32'(words_in_use) > WORDS) ? WIU_W'(WORDS) : words_in_use;
  assign n_hint        = HINT_W'(n_words);
  assign in_req        = req_map[s_axis_tdata[REQ_W-1:0]];
  assign ctrl          = bua_rom(step);
  assign s_axis_tready = ctrl.take;

  assign word_full  = (rdata == '1);
  assign cur_out    = (cur >= n_hint);
  assign steps_done = (steps == STEP_W'(n_words) + STEP_W'(1));
  assign unit_out   = ({1'b0, unit[UNIT_W-1:6]} >= n_words);
  assign free_mask  = 64'd1 << unit[5:0];
  assign bit_set    = |(rdata & free_mask);
  assign out_busy   = m_axis_tvalid && !m_axis_tready;
  assign share_t    = (shr >= n_hint) ? '0 : shr;
  assign low_clear  = ~rdata & (rdata + 64'd1);

  assign total_units = {n_words, 6'b0};
  assign free_units  = (total_units > allocated_count) ? total_units - allocated_count : '0;

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < 64; b++) begin
      if (low_clear[b]) begin
        bit_idx = bit_idx | 6'(b);
      end
    end
  end

  always_comb begin
    case (ctrl.cond)
      C_NONE:       cond_hit = 1'b0;
      C_NO_ITEM:    cond_hit = !s_axis_tvalid;
      C_CUR_OUT:    cond_hit = cur_out;
      C_WORD_FULL:  cond_hit = word_full;
      C_STEPS_DONE: cond_hit = steps_done;
      C_UNIT_OUT:   cond_hit = unit_out;
      C_OUT_BUSY:   cond_hit = out_busy;
      C_CLEAR_DONE: cond_hit = (32'(clr_addr) == WORDS - 1);
      default:      cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_next = ctrl.jump;
    end else if (ctrl.dispatch && s_axis_tuser == ACT_FREE) begin
      step_next = STEP_FRE_TEST;
    end else begin
      step_next = ctrl.next;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr;
    ram_wdata = rdata | (rdata + 64'd1);
    ram_raddr = ADDR_W'(cur);
    case (ctrl.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      OP_READ_UNIT: ram_raddr = ADDR_W'(unit[UNIT_W-1:6]);
      OP_SET_BIT:   ram_we    = !word_full;
      OP_CLEAR_BIT: begin
        ram_we    = bit_set;
        ram_wdata = rdata & ~free_mask;
      end
      default: ;
    endcase
  end

  bua_ram #(
    .WIDTH(64),
    .DEPTH(WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= STEP_CLEAR;
      clr_addr        <= '0;
      words_in_use    <= WIU_RESET;
      shared_hint     <= HINT_W'(REQUESTERS + 1);
      allocated_count <= '0;
      m_axis_tvalid   <= 1'b0;
      for (int i = 0; i < HINTS; i++) begin
        hint[i] <= HINT_W'(i + 1);
      end
    end else begin
      step <= step_next;
      if (cfg_valid) begin
        words_in_use <= cfg_data;
      end
      if (ctrl.op == OP_EMIT && !out_busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (ctrl.op)
        OP_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        OP_SET_BIT: begin
          if (!word_full) begin
            allocated_count <= allocated_count + FREE_W'(1);
            hint[req]       <= cur;
            shared_hint     <= shr;
          end
        end
        OP_CLEAR_BIT: begin
          if (bit_set) begin
            allocated_count <= allocated_count - FREE_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_TAKE: begin
        if (s_axis_tvalid) begin
          action  <= s_axis_tuser;
          req     <= in_req;
          unit    <= s_axis_tdata[REQ_W +: UNIT_W];
          cur     <= hint[in_req];
          shr     <= shared_hint;
          steps   <= '0;
          status  <= ST_OK;
          granted <= '0;
        end
      end
      OP_READ_CUR: rd_addr <= ram_raddr;
      OP_READ_UNIT: begin
        rd_addr <= ram_raddr;
        if (unit_out) begin
          status <= ST_BAD_FREE;
        end
      end
      OP_SET_BIT: begin
        if (!word_full) begin
          granted <= {cur[5:0], bit_idx};
        end
      end
      OP_SHARE: begin
        if (steps_done) begin
          status <= ST_NO_FREE;
        end else begin
          cur   <= share_t;
          shr   <= share_t + HINT_W'(1);
          steps <= steps + STEP_W'(1);
        end
      end
      OP_CLEAR_BIT: begin
        if (!bit_set || action != ACT_FREE) begin
          status <= ST_BAD_FREE;
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          m_axis_tuser <= status;
          m_axis_tdata <= {7'b0, free_units, granted};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ verif/tb_bitmap_unit_allocator_top.sv @@
// Self-checking testbench for bitmap_unit_allocator_top: directed, random, exhaustion
// and shrunk word count tests, checked against an in-bench predictor of the allocator.
// Depends on bua_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_bitmap_unit_allocator_top;
  import bua_pkg::*;

  typedef struct {
    status_t             status;
    logic [UNIT_W-1:0]   unit;
    logic [FREE_W-1:0]   free;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_valid = 1'b0;
  logic [15:0]       s_data = '0;
  logic              s_user = ACT_ALLOC;
  logic              m_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [WIU_W-1:0]  cfg_data = WIU_RESET;
  wire               s_ready;
  wire               m_valid;
  wire  [31:0]       m_data;
  wire  [1:0]        m_user;
  wire               cfg_ready;

  logic [63:0]       unit_map [DEF_WORDS];
  logic [WIU_W-1:0]  req_hint [DEF_REQUESTERS];
  logic [WIU_W-1:0]  rotor;
  logic [FREE_W-1:0] units_taken;
  logic [WIU_W-1:0]  words_in_use;
  alloc_result_t     pending_results[$];
  int                granted_units[$];
  status_t           last_status;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                mismatches = 0;

  bitmap_unit_allocator_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic reset_allocator_state();
    for (int i = 0; i < DEF_WORDS; i++) unit_map[i] = '0;
    for (int i = 0; i < DEF_REQUESTERS; i++) req_hint[i] = WIU_W'(i + 1);
    rotor = WIU_W'(DEF_REQUESTERS + 1);
    units_taken = '0;
    words_in_use = WIU_RESET;
    last_status = ST_OK;
  endtask

  function automatic alloc_result_t predict_request(logic action, logic [3:0] req,
                                                    logic [11:0] unit);
    alloc_result_t r;
    int n, idx, guard, t, bit_no, w, k;
    logic any;
    r.status = ST_OK;
    r.unit = '0;
    n = (words_in_use > DEF_WORDS) ? DEF_WORDS : words_in_use;
    if (action == ACT_ALLOC) begin
      any = 1'b0;
      for (w = 0; w < n; w++) if (unit_map[w] != '1) any = 1'b1;
      if (!any) begin
        r.status = ST_NO_FREE;
      end else begin
        idx = req_hint[req];
        guard = 0;
        while ((idx >= n || unit_map[idx] == '1) && guard < 2 * n + 2) begin
          t = rotor;
          if (t >= n) t = 0;
          rotor = WIU_W'(t + 1);
          idx = t;
          req_hint[req] = WIU_W'(idx);
          guard++;
        end
        if (idx >= n || unit_map[idx] == '1) begin
          r.status = ST_NO_FREE;
        end else begin
          bit_no = 0;
          while (bit_no < 63 && unit_map[idx][bit_no]) bit_no++;
          unit_map[idx][bit_no] = 1'b1;
          units_taken = units_taken + 1'b1;
          r.unit = UNIT_W'(idx * 64 + bit_no);
          granted_units.push_back(idx * 64 + bit_no);
        end
      end
    end else begin
      w = unit[11:6];
      if (w >= n || !unit_map[w][unit[5:0]]) begin
        r.status = ST_BAD_FREE;
      end else begin
        unit_map[w][unit[5:0]] = 1'b0;
        units_taken = units_taken - 1'b1;
        for (k = 0; k < granted_units.size(); k++) begin
          if (granted_units[k] == unit) begin
            granted_units.delete(k);
            break;
          end
        end
      end
    end
    r.free = FREE_W'((n * 64 > units_taken) ? n * 64 - units_taken : 0);
    return r;
  endfunction

  always @(negedge clk) begin
    m_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d unit %0d free %0d",
                   m_user, m_data[11:0], m_data[24:12]);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_user !== exp_r.status || m_data[11:0] !== exp_r.unit ||
            m_data[24:12] !== exp_r.free) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d unit %0d free %0d, got %0d %0d %0d",
                     exp_r.status, exp_r.unit, exp_r.free,
                     m_user, m_data[11:0], m_data[24:12]);
        end
      end
    end
  end

  task automatic send_request(input logic action, input logic [3:0] req,
                              input logic [11:0] unit);
    alloc_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_valid = 1'b0;
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_user = action;
    s_data = {unit, req};
    do @(posedge clk); while (!s_ready);
    r = predict_request(action, req, unit);
    last_status = r.status;
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_word_count(input logic [WIU_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    words_in_use = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_request();
    int pick;
    logic [11:0] unit;
    pick = $urandom_range(99);
    unit = 12'($urandom_range(4095));
    if (pick < 55)
      send_request(ACT_ALLOC, 4'($urandom_range(15)), unit);
    else if (pick < 90 && granted_units.size() > 0)
      send_request(ACT_FREE, 4'($urandom_range(15)),
                   12'(granted_units[$urandom_range(granted_units.size() - 1)]));
    else
      send_request(ACT_FREE, 4'($urandom_range(15)), unit);
  endtask

  task automatic run_traffic_phase(input int gap, input int stall,
                                   input logic [WIU_W-1:0] wiu, input int count);
    write_word_count(wiu);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) send_random_request();
    drain_results();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_directed_cases();
    write_word_count(7'd64);
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd15, 12'hfff);
    send_request(ACT_ALLOC, 4'd15, 12'd0);
    send_request(ACT_FREE, 4'd0, 12'd1025);
    send_request(ACT_FREE, 4'd15, 12'd1025);
    send_request(ACT_FREE, 4'd0, 12'd0);
    send_request(ACT_FREE, 4'd15, 12'hfff);
    send_request(ACT_ALLOC, 4'd5, 12'd0);
    send_request(ACT_FREE, 4'd0, 12'd64);
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    write_word_count(7'd18);
    send_request(ACT_FREE, 4'd3, 12'hfff);
    send_request(ACT_FREE, 4'd3, 12'd1024);
    send_request(ACT_ALLOC, 4'd15, 12'd0);
    send_request(ACT_ALLOC, 4'd3, 12'd0);
    send_request(ACT_FREE, 4'd5, 12'd384);
    send_request(ACT_ALLOC, 4'd5, 12'd0);
    write_word_count(7'd64);
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 7'd64, 50);
    run_traffic_phase(88, 0, 7'd18, 50);
    run_traffic_phase(0, 88, WIU_W'($urandom_range(18, 64)), 50);
    run_traffic_phase(17, 17, 7'd64, 50);
  endtask

  task automatic test_pool_exhaustion();
    int guard;
    write_word_count(7'd2);
    guard = 0;
    last_status = ST_OK;
    while (last_status != ST_NO_FREE && guard < 200) begin
      send_request(ACT_ALLOC, 4'($urandom_range(15)), 12'($urandom_range(4095)));
      guard++;
    end
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd15, 12'hfff);
    send_request(ACT_FREE, 4'd1, 12'd0);
    send_request(ACT_FREE, 4'd2, 12'd700);
    send_request(ACT_FREE, 4'd3, 12'd1151);
    repeat (4) send_request(ACT_ALLOC, 4'($urandom_range(15)), 12'd0);
    drain_results();
  endtask

  task automatic test_shrunk_word_count();
    write_word_count(7'd64);
    repeat (40) send_request(ACT_ALLOC, 4'($urandom_range(15)), 12'($urandom_range(4095)));
    write_word_count(7'd18);
    send_request(ACT_FREE, 4'd0, 12'd1280);
    send_request(ACT_FREE, 4'd0, 12'd5);
    send_request(ACT_ALLOC, 4'd7, 12'd0);
    send_request(ACT_ALLOC, 4'd9, 12'd0);
    run_traffic_phase(0, 0, 7'd64, 30);
  endtask

  initial begin
    reset_allocator_state();
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_random_traffic();
    test_pool_exhaustion();
    test_shrunk_word_count();
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
